>>> src/ctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and constants of the cruise throttle regulator.
// ----------------------------------------------------------------------------
package ctr_pkg;

    // Field widths
    localparam int SPEED_W    = 11;
    localparam int THR_W      = 8;
    localparam int SHOWN_W    = 7;
    localparam int MIN_SPD_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int WORD_IN_W  = 24;
    localparam int WORD_OUT_W = 24;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENGAGE_MIN = 3'd0,
        REG_CEILING    = 3'd1,
        REG_FIRST_CAP  = 3'd2,
        REG_LOW_CAP    = 3'd3,
        REG_TOP_CAP    = 3'd4
    } ctr_reg_e;

    // Register reset values
    localparam logic [MIN_SPD_W-1:0] ENGAGE_MIN_RST = 10'd200;
    localparam logic [THR_W-1:0]     CEILING_RST    = 8'd80;
    localparam logic [THR_W-1:0]     FIRST_CAP_RST  = 8'd20;
    localparam logic [THR_W-1:0]     LOW_CAP_RST    = 8'd30;
    localparam logic [THR_W-1:0]     TOP_CAP_RST    = 8'd40;
    localparam logic [THR_W-1:0]     THROTTLE_RST   = 8'd40;

    // Speed constants (12-bit signed compare domain)
    localparam logic signed [11:0] SPD_SLOW_LO  = 12'sd20;
    localparam logic signed [11:0] SPD_SLOW_HI  = 12'sd25;
    localparam logic signed [11:0] BAND_WIDE    = 12'sd10;
    localparam logic signed [11:0] BAND_NARROW  = 12'sd5;

    // Throttle steps (11-bit signed working domain)
    localparam logic signed [10:0] THR_STEP_BIG   = 11'sd10;
    localparam logic signed [10:0] THR_STEP_SMALL = 11'sd5;

    // Divide by ten: x * 205 >> 11, exact for x below 1029
    localparam logic [7:0] RECIP_TEN  = 8'd205;
    localparam int         RECIP_SHIFT = 11;

    typedef struct packed {
        logic [MIN_SPD_W-1:0] engage_min;
        logic [THR_W-1:0]     ceiling;
        logic [THR_W-1:0]     first_cap;
        logic [THR_W-1:0]     low_cap;
        logic [THR_W-1:0]     top_cap;
    } ctr_cfg_t;

    typedef struct packed {
        logic                      engine;
        logic                      gear_low;
        logic                      gear_top;
        logic                      gas;
        logic                      brake;
        logic                      cruise;
        logic                      target_latched;
        logic signed [SPEED_W-1:0] target_speed;
        logic [THR_W-1:0]          throttle;
    } ctr_state_t;

    // Regulator state after reset
    localparam ctr_state_t STATE_RST = '{
        engine:         1'b0,
        gear_low:       1'b0,
        gear_top:       1'b0,
        gas:            1'b0,
        brake:          1'b0,
        cruise:         1'b0,
        target_latched: 1'b0,
        target_speed:   '0,
        throttle:       THROTTLE_RST
    };

    typedef struct packed {
        logic                      top_switch;
        logic                      low_switch;
        logic                      engine_switch;
        logic                      cruise_held;
        logic                      brake_held;
        logic                      gas_held;
        logic signed [SPEED_W-1:0] speed_now;
    } ctr_in_t;

    typedef struct packed {
        logic [SHOWN_W-1:0] target_shown;
        logic               engine_running;
        logic               cruise_active;
        logic [THR_W-1:0]   throttle_out;
    } ctr_out_t;

endpackage

>>> src/ctr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_step
// One control tick: switch rules, button rules, throttle step and clamp.
// ----------------------------------------------------------------------------
module ctr_step
    import ctr_pkg::*;
(
    input  ctr_cfg_t   cfg,
    input  ctr_state_t st,
    input  ctr_in_t    item,
    output ctr_state_t st_next,
    output ctr_out_t   result
);

    logic signed [11:0] v;
    logic signed [11:0] tgt_ext;
    logic signed [11:0] t0;
    logic signed [11:0] t1;
    logic signed [11:0] t2;
    logic signed [10:0] thr;
    logic signed [10:0] cap;
    logic               cap_en;
    logic [17:0]        prod;

    assign v = {item.speed_now[SPEED_W-1], item.speed_now};

    always_comb
    begin
        st_next = st;
        thr     = {3'b000, st.throttle};
        cap     = {3'b000, cfg.first_cap};
        cap_en  = 1'b0;
        tgt_ext = '0;
        t0      = '0;
        t1      = '0;
        t2      = '0;

        // Switch rules: engine holds while moving
        if (item.engine_switch)
            st_next.engine = 1'b1;
        else if (v == 12'sd0)
            st_next.engine = 1'b0;
        st_next.gear_low = item.low_switch;
        if (!item.low_switch && !st.gear_top)
            st_next.cruise = 1'b0;
        st_next.gear_top = item.top_switch;
        if (!item.top_switch)
            st_next.cruise = 1'b0;

        // Button rules: engage uses last tick's pedal states, a pedal held now cancels
        if (item.cruise_held && !st.brake && !st.gas && st_next.gear_top &&
            (v >= $signed({2'b00, cfg.engage_min})))
            st_next.cruise = 1'b1;
        st_next.gas   = item.gas_held;
        st_next.brake = item.brake_held;
        if (item.gas_held || item.brake_held)
            st_next.cruise = 1'b0;

        // Throttle step
        if (st_next.engine)
        begin
            if (st_next.cruise)
            begin
                if (!st.target_latched)
                begin
                    st_next.target_latched = 1'b1;
                    if ((v > SPD_SLOW_LO) && (v < SPD_SLOW_HI))
                        st_next.target_speed = SPD_SLOW_HI[SPEED_W-1:0];
                    else
                        st_next.target_speed = item.speed_now;
                end
                tgt_ext = {st_next.target_speed[SPEED_W-1], st_next.target_speed};
                t0 = tgt_ext - BAND_WIDE;
                t1 = tgt_ext + BAND_NARROW;
                t2 = tgt_ext + BAND_WIDE;
                if (v < t0)
                    thr = thr + THR_STEP_BIG;
                else if ((v > t0) && (v < t1))
                    thr = thr + THR_STEP_SMALL;
                else if ((v > t1) && (v < t2))
                    thr = thr - THR_STEP_SMALL;
                else if (v > t2)
                    thr = thr - THR_STEP_BIG;
            end
            else
            begin
                st_next.target_latched = 1'b0;
                if (st_next.gas)
                begin
                    thr = thr + THR_STEP_SMALL;
                    // Pick the gear cap; both gears on means no cap
                    if (!st_next.gear_low && !st_next.gear_top)
                    begin
                        cap    = {3'b000, cfg.first_cap};
                        cap_en = 1'b1;
                    end
                    else if (st_next.gear_low && !st_next.gear_top)
                    begin
                        cap    = {3'b000, cfg.low_cap};
                        cap_en = 1'b1;
                    end
                    else if (!st_next.gear_low && st_next.gear_top)
                    begin
                        cap    = {3'b000, cfg.top_cap};
                        cap_en = 1'b1;
                    end
                    if (cap_en && (thr > cap))
                        thr = cap;
                end
            end
        end
        else
        begin
            thr = '0;
        end

        // Clamp to 0..ceiling
        if (thr < 11'sd0)
            st_next.throttle = '0;
        else if (thr > $signed({3'b000, cfg.ceiling}))
            st_next.throttle = cfg.ceiling;
        else
            st_next.throttle = thr[THR_W-1:0];
    end

    // Display the target in whole m/s
    assign prod = 18'(st_next.target_speed[SPEED_W-2:0]) * 18'(RECIP_TEN);

    always_comb
    begin
        result.throttle_out   = st_next.throttle;
        result.cruise_active  = st_next.cruise;
        result.engine_running = st_next.engine;
        if (st_next.cruise && st_next.target_latched &&
            (st_next.target_speed > 11'sd0))
            result.target_shown = prod[RECIP_SHIFT +: SHOWN_W];
        else
            result.target_shown = '0;
    end

endmodule

>>> src/cruise_throttle_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cruise_throttle_regulator
// Cruise control and throttle regulation, one control tick per input word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: sensor and switch word
//  m_*     | out | m_tvalid/m_tready  | m_tdata: throttle and status word
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data: register write
//
// One word per cycle sustained while m_tready is high; a word passes the
// input, then result register; tick logic between is one combinational pass.
// Regulator state advances when a word moves from the input to the result
// register, so consecutive words see each other's updates without a bubble.
// Reset clears state, sets throttle to 40 and loads register defaults.
// A stalled result holds; the input register still takes one more word.
// ----------------------------------------------------------------------------
module cruise_throttle_regulator
    import ctr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [10:0] speed_now, [11] gas_held, [12] brake_held, [13] cruise_held,
    // [14] engine_switch, [15] low_switch, [16] top_switch, [23:17] zero
    input  logic [WORD_IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] throttle_out, [8] cruise_active, [9] engine_running,
    // [16:10] target_shown, [23:17] zero
    output logic [WORD_OUT_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctr_cfg_t   cfg_reg;
    ctr_state_t st_reg;
    ctr_state_t st_next;
    ctr_in_t    in_reg;
    ctr_out_t   out_reg;
    ctr_out_t   result;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_reg};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.engage_min <= ENGAGE_MIN_RST;
            cfg_reg.ceiling    <= CEILING_RST;
            cfg_reg.first_cap  <= FIRST_CAP_RST;
            cfg_reg.low_cap    <= LOW_CAP_RST;
            cfg_reg.top_cap    <= TOP_CAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENGAGE_MIN: cfg_reg.engage_min <= cfg_data;
                REG_CEILING:    cfg_reg.ceiling    <= cfg_data[THR_W-1:0];
                REG_FIRST_CAP:  cfg_reg.first_cap  <= cfg_data[THR_W-1:0];
                REG_LOW_CAP:    cfg_reg.low_cap    <= cfg_data[THR_W-1:0];
                REG_TOP_CAP:    cfg_reg.top_cap    <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register: take a word whenever the slot frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= ctr_in_t'(s_tdata[16:0]);
    end

    ctr_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next),
        .result  (result)
    );

    // Regulator state: advance with each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_RST;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    // Checks
    a_engine_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_reg.engine_running) |-> (out_reg.throttle_out == '0))
        else $error("throttle nonzero with engine off");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.throttle_out <= cfg_reg.ceiling))
        else $error("throttle above ceiling");

    a_shown_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.target_shown != '0)) |-> out_reg.cruise_active)
        else $error("target shown without cruise");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without output back-pressure");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (st_reg == $past(st_reg)))
        else $error("state moved without a word");

endmodule
